### hw/rtl/tie_pkg.sv
package tie_pkg;

  // Request kinds carried on in_tuser
  localparam logic [1:0] KIND_EXEC    = 2'd0;
  localparam logic [1:0] KIND_SET_REG = 2'd1;
  localparam logic [1:0] KIND_SET_MEM = 2'd2;
  localparam logic [1:0] KIND_READ    = 2'd3;

  // Instruction opcodes, bits 31..26
  localparam logic [5:0] OPC_ADD  = 6'd1;
  localparam logic [5:0] OPC_SUB  = 6'd2;
  localparam logic [5:0] OPC_ADDI = 6'd17;
  localparam logic [5:0] OPC_BNE  = 6'd18;
  localparam logic [5:0] OPC_BEQ  = 6'd19;
  localparam logic [5:0] OPC_JUMP = 6'd33;
  localparam logic [5:0] OPC_LD   = 6'd49;
  localparam logic [5:0] OPC_ST   = 6'd50;

  // Channel widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 104;

  // Decode queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register file geometry
  localparam int NUM_REGS = 32;

  // Internal operation classes
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADD,
    OP_SUB,
    OP_ADDI,
    OP_BNE,
    OP_BEQ,
    OP_JUMP,
    OP_LD,
    OP_ST,
    OP_SET_REG,
    OP_SET_MEM,
    OP_READ
  } op_t;

  // One decoded request
  typedef struct packed {
    op_t         op;
    logic [4:0]  ra;     // register read on port A
    logic [4:0]  rb;     // register read on port B
    logic [4:0]  rd;     // register written
    logic [4:0]  boff;   // address offset for load and store
    logic [9:0]  maddr;  // memory word for preload and read back
    logic [31:0] data;   // immediate or preload value
  } uop_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RED1,
    ST_RED2,
    ST_RED3,
    ST_MEM
  } state_t;

endpackage

### hw/rtl/tie_ram.sv
module tie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/tie_queue.sv
module tie_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tie_pkg::uop_t push_uop,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tie_pkg::uop_t head_uop
);

  tie_pkg::uop_t                entries_r [tie_pkg::QUEUE_DEPTH];
  logic [tie_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [tie_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [tie_pkg::QPTR_W:0]     count_r;
  logic [tie_pkg::QPTR_W:0]     count_nxt;

  assign full       = (count_r == (tie_pkg::QPTR_W + 1)'(tie_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_uop   = entries_r[rd_ptr_r];

  // Track fill level
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_uop;
    end
  end

endmodule

### hw/rtl/tie_front.sv
module tie_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // instruction[31:0], reg_index[36:32], mem_address[46:37], value[78:47]
  input  logic [tie_pkg::IN_TDATA_W-1:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]                     in_tuser,
  input  logic                           clear_busy,
  input  logic                           q_full,
  output logic                           q_push,
  output tie_pkg::uop_t                  q_uop
);

  logic [31:0] instr;
  logic [4:0]  reg_index;
  logic [9:0]  mem_address;
  logic [31:0] value;
  logic [5:0]  opc;
  logic [4:0]  fa;
  logic [4:0]  fb;
  logic [4:0]  fc;
  logic [31:0] imm;

  assign instr       = in_tdata[31:0];
  assign reg_index   = in_tdata[36:32];
  assign mem_address = in_tdata[46:37];
  assign value       = in_tdata[78:47];

  assign opc = instr[31:26];
  assign fa  = instr[25:21];
  assign fb  = instr[20:16];
  assign fc  = instr[15:11];
  assign imm = {{16{instr[15]}}, instr[15:0]};

  // Take requests while the queue has room and the memory is cleared
  assign in_tready = !q_full && !clear_busy;
  assign q_push    = in_tvalid && in_tready;

  // Classify the request and pick register ports
  always_comb begin
    q_uop       = '0;
    q_uop.op    = tie_pkg::OP_NOP;
    q_uop.maddr = mem_address;
    case (in_tuser)
      tie_pkg::KIND_EXEC: begin
        case (opc)
          tie_pkg::OPC_ADD: begin
            q_uop.op = tie_pkg::OP_ADD;
            q_uop.ra = fb;
            q_uop.rb = fc;
            q_uop.rd = fa;
          end
          tie_pkg::OPC_SUB: begin
            q_uop.op = tie_pkg::OP_SUB;
            q_uop.ra = fb;
            q_uop.rb = fc;
            q_uop.rd = fa;
          end
          tie_pkg::OPC_ADDI: begin
            q_uop.op   = tie_pkg::OP_ADDI;
            q_uop.ra   = fb;
            q_uop.rd   = fa;
            q_uop.data = imm;
          end
          tie_pkg::OPC_BNE: begin
            q_uop.op   = tie_pkg::OP_BNE;
            q_uop.ra   = fa;
            q_uop.rb   = fb;
            q_uop.data = imm;
          end
          tie_pkg::OPC_BEQ: begin
            q_uop.op   = tie_pkg::OP_BEQ;
            q_uop.ra   = fa;
            q_uop.rb   = fb;
            q_uop.data = imm;
          end
          tie_pkg::OPC_JUMP: begin
            q_uop.op   = tie_pkg::OP_JUMP;
            q_uop.data = imm;
          end
          tie_pkg::OPC_LD: begin
            q_uop.op   = tie_pkg::OP_LD;
            q_uop.rb   = fc;
            q_uop.rd   = fa;
            q_uop.boff = fb;
          end
          tie_pkg::OPC_ST: begin
            q_uop.op   = tie_pkg::OP_ST;
            q_uop.ra   = fa;
            q_uop.rb   = fc;
            q_uop.boff = fb;
          end
          default: begin
            q_uop.op = tie_pkg::OP_NOP;
          end
        endcase
      end
      tie_pkg::KIND_SET_REG: begin
        q_uop.op   = tie_pkg::OP_SET_REG;
        q_uop.rd   = reg_index;
        q_uop.data = value;
      end
      tie_pkg::KIND_SET_MEM: begin
        q_uop.op   = tie_pkg::OP_SET_MEM;
        q_uop.data = value;
      end
      tie_pkg::KIND_READ: begin
        q_uop.op = tie_pkg::OP_READ;
        q_uop.ra = reg_index;
      end
      default: begin
        q_uop.op = tie_pkg::OP_NOP;
      end
    endcase
  end

endmodule

### hw/rtl/tie_back.sv
module tie_back #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [15:0]                     prog_len,
  input  logic                            q_valid,
  input  tie_pkg::uop_t                   q_uop,
  output logic                            q_pop,
  output logic                            clear_busy,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tie_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [63:0] RECIP_W = 64'h1_0000_0000 / MEM_DEPTH;
  localparam logic [31:0] RECIP   = RECIP_W[31:0];
  localparam logic [31:0] MDEP    = 32'(MEM_DEPTH);
  localparam logic [AW:0] MDEP_N  = (AW + 1)'(MEM_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(MEM_DEPTH - 1);

  tie_pkg::state_t state_r;
  tie_pkg::state_t state_nxt;
  tie_pkg::uop_t   cur_r;

  logic [AW-1:0]               clr_cnt_r;
  logic [tie_pkg::NUM_REGS-1:0] reg_valid_r;
  logic [31:0]                 pc_r;
  logic [31:0]                 x_r;
  logic [31:0]                 quo_r;
  logic [AW:0]                 rem_r;

  logic [31:0] ram_a_q;
  logic [31:0] ram_b_q;
  logic [31:0] mem_q;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [63:0] prod;
  logic [31:0] rem_full;
  logic [AW:0] fold;
  logic [AW-1:0] red_addr;

  logic          reg_re;
  logic          reg_we;
  logic          finish;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic          out_free;
  logic          is_mem_op;
  logic          writes_reg;
  logic [31:0]   wr_val;
  logic [31:0]   pc_base;
  logic [31:0]   pc_inc;
  logic [31:0]   pc_new;
  logic          halted;

  logic        out_tvalid_r;
  logic [31:0] out_pc_r;
  logic        out_halted_r;
  logic [31:0] out_rv_r;
  logic [31:0] out_mv_r;

  // Two register-file copies give two read ports; register 0 lives in pc_r
  tie_ram #(.WIDTH(32), .DEPTH(tie_pkg::NUM_REGS)) u_reg_a (
    .clk   (clk),
    .we    (reg_we),
    .waddr (cur_r.rd),
    .wdata (wr_val),
    .re    (reg_re),
    .raddr (q_uop.ra),
    .rdata (ram_a_q)
  );

  tie_ram #(.WIDTH(32), .DEPTH(tie_pkg::NUM_REGS)) u_reg_b (
    .clk   (clk),
    .we    (reg_we),
    .waddr (cur_r.rd),
    .wdata (wr_val),
    .re    (reg_re),
    .raddr (q_uop.rb),
    .rdata (ram_b_q)
  );

  tie_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_q)
  );

  // Operands: register 0 is the counter, unwritten registers read zero
  assign opa = (cur_r.ra == '0) ? pc_r : (reg_valid_r[cur_r.ra] ? ram_a_q : '0);
  assign opb = (cur_r.rb == '0) ? pc_r : (reg_valid_r[cur_r.rb] ? ram_b_q : '0);

  assign is_mem_op = (cur_r.op == tie_pkg::OP_LD) || (cur_r.op == tie_pkg::OP_ST) ||
                     (cur_r.op == tie_pkg::OP_SET_MEM) || (cur_r.op == tie_pkg::OP_READ);
  assign writes_reg = (cur_r.op == tie_pkg::OP_ADD) || (cur_r.op == tie_pkg::OP_SUB) ||
                      (cur_r.op == tie_pkg::OP_ADDI) || (cur_r.op == tie_pkg::OP_SET_REG) ||
                      (cur_r.op == tie_pkg::OP_LD);

  // Address reduction modulo the memory depth: reciprocal estimate, then one fold
  assign prod     = x_r * RECIP;
  assign rem_full = x_r - quo_r * MDEP;
  assign fold     = (rem_r >= MDEP_N) ? rem_r - MDEP_N : rem_r;
  assign red_addr = fold[AW-1:0];

  assign out_free   = !out_tvalid_r || out_tready;
  assign clear_busy = (state_r == tie_pkg::ST_CLEAR);

  // Register write value
  always_comb begin
    case (cur_r.op)
      tie_pkg::OP_ADD:     wr_val = opa + opb;
      tie_pkg::OP_SUB:     wr_val = opa - opb;
      tie_pkg::OP_ADDI:    wr_val = opa + cur_r.data;
      tie_pkg::OP_SET_REG: wr_val = cur_r.data;
      tie_pkg::OP_LD:      wr_val = mem_q;
      default:             wr_val = '0;
    endcase
  end

  // Counter step
  always_comb begin
    case (cur_r.op)
      tie_pkg::OP_ADD, tie_pkg::OP_SUB, tie_pkg::OP_ADDI,
      tie_pkg::OP_LD, tie_pkg::OP_ST: pc_inc = 32'd1;
      tie_pkg::OP_BNE:  pc_inc = (opa != opb) ? cur_r.data : 32'd1;
      tie_pkg::OP_BEQ:  pc_inc = (opa == opb) ? cur_r.data : 32'd1;
      tie_pkg::OP_JUMP: pc_inc = cur_r.data;
      default:          pc_inc = '0;
    endcase
  end

  // A write to register 0 lands before the step is added
  assign pc_base = (writes_reg && cur_r.rd == '0) ? wr_val : pc_r;
  assign pc_new  = pc_base + pc_inc;
  assign halted  = pc_new[31] || (pc_new >= {16'd0, prog_len});

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    reg_re    = 1'b0;
    finish    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = red_addr;
    mem_wdata = (cur_r.op == tie_pkg::OP_ST) ? opa : cur_r.data;
    case (state_r)
      tie_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = tie_pkg::ST_IDLE;
        end
      end
      tie_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          reg_re    = 1'b1;
          state_nxt = tie_pkg::ST_EXEC;
        end
      end
      tie_pkg::ST_EXEC: begin
        if (is_mem_op) begin
          state_nxt = tie_pkg::ST_RED1;
        end else if (out_free) begin
          finish    = 1'b1;
          state_nxt = tie_pkg::ST_IDLE;
        end
      end
      tie_pkg::ST_RED1: begin
        state_nxt = tie_pkg::ST_RED2;
      end
      tie_pkg::ST_RED2: begin
        state_nxt = tie_pkg::ST_RED3;
      end
      tie_pkg::ST_RED3: begin
        if ((cur_r.op == tie_pkg::OP_LD) || (cur_r.op == tie_pkg::OP_READ)) begin
          mem_re    = 1'b1;
          state_nxt = tie_pkg::ST_MEM;
        end else if (out_free) begin
          finish    = 1'b1;
          mem_we    = 1'b1;
          state_nxt = tie_pkg::ST_IDLE;
        end
      end
      tie_pkg::ST_MEM: begin
        if (out_free) begin
          finish    = 1'b1;
          state_nxt = tie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tie_pkg::ST_IDLE;
      end
    endcase
  end

  assign reg_we = finish && writes_reg && (cur_r.rd != '0);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tie_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      reg_valid_r  <= '0;
      pc_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tie_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (reg_we) begin
        reg_valid_r[cur_r.rd] <= 1'b1;
      end
      if (finish) begin
        pc_r         <= pc_new;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_uop;
    end
    if (state_r == tie_pkg::ST_EXEC) begin
      if ((cur_r.op == tie_pkg::OP_LD) || (cur_r.op == tie_pkg::OP_ST)) begin
        x_r <= {27'd0, cur_r.boff} + opb;
      end else begin
        x_r <= {22'd0, cur_r.maddr};
      end
    end
    if (state_r == tie_pkg::ST_RED1) begin
      quo_r <= prod[63:32];
    end
    if (state_r == tie_pkg::ST_RED2) begin
      rem_r <= rem_full[AW:0];
    end
    if (finish) begin
      out_pc_r     <= pc_new;
      out_halted_r <= halted;
      out_rv_r     <= (cur_r.op == tie_pkg::OP_READ) ? opa : '0;
      out_mv_r     <= (cur_r.op == tie_pkg::OP_READ) ? mem_q : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_mv_r, out_rv_r, out_halted_r, out_pc_r};

endmodule

### hw/rtl/toy_isa_instruction_executor.sv
// Executor for a small four-format instruction set with register 0 as the
// program counter, 32 registers and a MEM_DEPTH-word data memory. Each request
// on the input stream (in_tuser: execute, preload register, preload memory
// word, read back) yields exactly one result carrying the new counter, the
// halted flag and read-back data. A front end decodes requests into a
// two-entry queue, so input is taken while the back end works and while a
// result waits in the output register. Arithmetic, branch, jump and register
// preload read the register-file RAMs, then execute and write back. Store,
// memory preload, load and read back do the same read and then pass the
// memory address through a modulo-MEM_DEPTH reduction (a registered reciprocal
// multiply, a registered back-multiply, then a fold that feeds the address of
// the single data-memory port). After reset the data memory is zeroed in a
// clearing pass over every word during which in_tready stays low;
// program_length may be written on the cfg port at any time the block is idle.
module toy_isa_instruction_executor #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [15:0]                     cfg_wr_data,    // program_length
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // instruction[31:0], reg_index[36:32], mem_address[46:37], value[78:47]
  input  logic [tie_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pc_after[31:0], halted[32], reg_value[64:33], mem_value[96:65]
  output logic [tie_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [15:0]   prog_len_r;
  logic          clear_busy;
  logic          q_full;
  logic          q_push;
  tie_pkg::uop_t q_push_uop;
  logic          q_pop;
  logic          q_valid;
  tie_pkg::uop_t q_head;

  // Program length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else if (cfg_wr_en) begin
      prog_len_r <= cfg_wr_data;
    end
  end

  tie_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_uop      (q_push_uop)
  );

  tie_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_uop   (q_push_uop),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_uop   (q_head)
  );

  tie_back #(.MEM_DEPTH(MEM_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .prog_len   (prog_len_r),
    .q_valid    (q_valid),
    .q_uop      (q_head),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int MEM_DEPTH  = 1024;
  localparam int IDLE_LIMIT = 5000;
  localparam int SEG_ITEMS  = 292;
  localparam int SETTLE     = 12;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        halted;
    logic [31:0] reg_value;
    logic [31:0] mem_value;
  } status_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] instr;
    logic [4:0]  ridx;
    logic [9:0]  maddr;
    logic [31:0] value;
    bit          set_len;
    logic [15:0] len;
    bit          pinned;
    status_t     want;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [15:0]                     cfg_wr_data = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [tie_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]                      in_tuser = tie_pkg::KIND_EXEC;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tie_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Shadow machine state
  logic [31:0] shadow_regs [32];
  logic [31:0] shadow_mem [MEM_DEPTH];
  logic [15:0] shadow_len;

  status_t  status_q[$];
  dir_row_t dir_rows[$];

  int send_idle = 0;
  int recv_idle = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_lengths = 0;
  int quiet_cycles = 0;

  logic [5:0] legal_ops [8] = '{tie_pkg::OPC_ADD, tie_pkg::OPC_SUB, tie_pkg::OPC_ADDI,
                                tie_pkg::OPC_BNE, tie_pkg::OPC_BEQ, tie_pkg::OPC_JUMP,
                                tie_pkg::OPC_LD, tie_pkg::OPC_ST};

  toy_isa_instruction_executor #(
    .MEM_DEPTH(MEM_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] instr_word(logic [5:0] op, logic [4:0] a, logic [4:0] b,
                                             logic [15:0] low);
    return {op, a, b, low};
  endfunction

  function automatic logic [tie_pkg::IN_TDATA_W-1:0] pack_request(logic [31:0] instr,
                                                                  logic [4:0] ridx,
                                                                  logic [9:0] maddr,
                                                                  logic [31:0] value);
    return {1'b0, value, maddr, ridx, instr};
  endfunction

  // Run one instruction on the shadow state
  function automatic void exec_instr(logic [31:0] w);
    logic [5:0]  op;
    logic [4:0]  a, b, c;
    logic [31:0] imm, addr;
    op   = w[31:26];
    a    = w[25:21];
    b    = w[20:16];
    c    = w[15:11];
    imm  = {{16{w[15]}}, w[15:0]};
    addr = (32'(b) + shadow_regs[c]) % MEM_DEPTH;
    case (op)
      tie_pkg::OPC_ADD: begin
        shadow_regs[a] = shadow_regs[b] + shadow_regs[c];
        shadow_regs[0] += 32'd1;
      end
      tie_pkg::OPC_SUB: begin
        shadow_regs[a] = shadow_regs[b] - shadow_regs[c];
        shadow_regs[0] += 32'd1;
      end
      tie_pkg::OPC_ADDI: begin
        shadow_regs[a] = shadow_regs[b] + imm;
        shadow_regs[0] += 32'd1;
      end
      tie_pkg::OPC_BNE: shadow_regs[0] += (shadow_regs[a] != shadow_regs[b]) ? imm : 32'd1;
      tie_pkg::OPC_BEQ: shadow_regs[0] += (shadow_regs[a] == shadow_regs[b]) ? imm : 32'd1;
      tie_pkg::OPC_JUMP: shadow_regs[0] += imm;
      tie_pkg::OPC_LD: begin
        shadow_regs[a] = shadow_mem[addr];
        shadow_regs[0] += 32'd1;
      end
      tie_pkg::OPC_ST: begin
        shadow_mem[addr] = shadow_regs[a];
        shadow_regs[0] += 32'd1;
      end
      default: ;
    endcase
  endfunction

  // Apply one request to the shadow state and return the status it yields
  function automatic status_t step_machine(logic [1:0] kind,
                                           logic [tie_pkg::IN_TDATA_W-1:0] data);
    status_t     st;
    logic [4:0]  ridx;
    logic [31:0] maddr;
    ridx  = data[36:32];
    maddr = 32'(data[46:37]) % MEM_DEPTH;
    st    = '0;
    case (kind)
      tie_pkg::KIND_EXEC:    exec_instr(data[31:0]);
      tie_pkg::KIND_SET_REG: shadow_regs[ridx] = data[78:47];
      tie_pkg::KIND_SET_MEM: shadow_mem[maddr] = data[78:47];
      default: begin
        st.reg_value = shadow_regs[ridx];
        st.mem_value = shadow_mem[maddr];
      end
    endcase
    st.pc_after = shadow_regs[0];
    st.halted   = shadow_regs[0][31] || (shadow_regs[0] >= {16'd0, shadow_len});
    return st;
  endfunction

  // Present one request, hold it until taken, then record its status
  task automatic send_request(input logic [1:0] kind,
                              input logic [tie_pkg::IN_TDATA_W-1:0] data,
                              input bit pinned, input status_t want);
    status_t st;
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    st = step_machine(kind, data);
    status_q.push_back(pinned ? want : st);
    n_sent++;
  endtask

  // Drain all outstanding work, then write program_length
  task automatic set_length(input logic [15:0] len);
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    shadow_len = len;
    n_lengths++;
  endtask

  function automatic void random_request(output logic [1:0] kind,
                                         output logic [tie_pkg::IN_TDATA_W-1:0] data);
    logic [31:0] instr, value;
    logic [4:0]  ridx, a, b;
    logic [5:0]  op;
    logic [15:0] low;
    int          pick;
    pick  = $urandom_range(0, 99);
    ridx  = 5'($urandom);
    value = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 2047);
    instr = $urandom;
    if (pick < 68) begin
      kind = tie_pkg::KIND_EXEC;
      if ($urandom_range(0, 99) < 88) begin
        op  = legal_ops[$urandom_range(0, 7)];
        a   = 5'($urandom);
        b   = 5'($urandom);
        low = 16'($urandom);
        // keep branch and jump offsets mostly short so the counter stays near the program
        if ((op == tie_pkg::OPC_BNE || op == tie_pkg::OPC_BEQ || op == tie_pkg::OPC_JUMP) &&
            $urandom_range(0, 1) == 0)
          low = 16'($urandom_range(0, 16)) - 16'd8;
        if ((op == tie_pkg::OPC_BNE || op == tie_pkg::OPC_BEQ) && $urandom_range(0, 99) < 30)
          b = a;
        instr = instr_word(op, a, b, low);
      end
    end else if (pick < 78) begin
      kind = tie_pkg::KIND_SET_REG;
      // pull the counter back into the program now and then
      if ($urandom_range(0, 99) < 15) begin
        ridx  = 5'd0;
        value = $urandom_range(0, 350);
      end
    end else if (pick < 86) begin
      kind = tie_pkg::KIND_SET_MEM;
    end else begin
      kind = tie_pkg::KIND_READ;
    end
    data = pack_request(instr, ridx, 10'($urandom), value);
  endfunction

  task automatic add_row(input logic [1:0] kind, input logic [31:0] instr,
                         input logic [4:0] ridx, input logic [9:0] maddr,
                         input logic [31:0] value);
    dir_row_t r;
    r = '{kind: kind, instr: instr, ridx: ridx, maddr: maddr, value: value,
          set_len: 1'b0, len: '0, pinned: 1'b0, want: '0};
    dir_rows.push_back(r);
  endtask

  task automatic pin_last(input logic [31:0] pc, input logic halted, input logic [31:0] rv,
                          input logic [31:0] mv);
    dir_rows[$].pinned = 1'b1;
    dir_rows[$].want   = '{pc, halted, rv, mv};
  endtask

  task automatic add_length_row(input logic [15:0] len);
    dir_row_t r;
    r = '{kind: tie_pkg::KIND_READ, instr: '0, ridx: '0, maddr: '0, value: '0,
          set_len: 1'b1, len: len, pinned: 1'b0, want: '0};
    dir_rows.push_back(r);
  endtask

  // Check each returned status against the oldest one outstanding
  always @(posedge clk) begin
    status_t got, exp_st;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[31:0], out_tdata[32], out_tdata[64:33], out_tdata[96:65]};
      if (status_q.size() == 0) begin
        $error("status returned with none outstanding: pc_after %h", got.pc_after);
        n_errors++;
      end else begin
        exp_st = status_q.pop_front();
        n_checked++;
        if (got.pc_after !== exp_st.pc_after) begin
          $error("pc_after: expected %h, got %h", exp_st.pc_after, got.pc_after);
          n_errors++;
        end
        if (got.halted !== exp_st.halted) begin
          $error("halted: expected %b, got %b", exp_st.halted, got.halted);
          n_errors++;
        end
        if (got.reg_value !== exp_st.reg_value) begin
          $error("reg_value: expected %h, got %h", exp_st.reg_value, got.reg_value);
          n_errors++;
        end
        if (got.mem_value !== exp_st.mem_value) begin
          $error("mem_value: expected %h, got %h", exp_st.mem_value, got.mem_value);
          n_errors++;
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [1:0]                     kind;
    logic [tie_pkg::IN_TDATA_W-1:0] data;
    logic [15:0]                    seg_len [6];
    dir_row_t                       r;

    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    shadow_len = '0;

    // Directed requests: reset state, extremes, every opcode, corner cases
    add_row(tie_pkg::KIND_READ, '0, 5'd0, 10'd0, '0);
    pin_last(32'd0, 1'b1, 32'd0, 32'd0);
    add_row(tie_pkg::KIND_READ, 32'hFFFF_FFFF, 5'd31, 10'd1023, 32'hFFFF_FFFF);
    pin_last(32'd0, 1'b1, 32'd0, 32'd0);
    add_row(tie_pkg::KIND_SET_REG, '0, 5'd5, 10'd0, 32'h7FFF_FFFF);
    pin_last(32'd0, 1'b1, 32'd0, 32'd0);
    add_row(tie_pkg::KIND_SET_REG, '0, 5'd6, 10'd0, 32'h8000_0000);
    pin_last(32'd0, 1'b1, 32'd0, 32'd0);
    add_length_row(16'd100);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_ADD, 5'd7, 5'd5, {5'd5, 11'd0}),
            '0, '0, '0);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_SUB, 5'd8, 5'd6, {5'd5, 11'h7FF}),
            '0, '0, '0);
    add_row(tie_pkg::KIND_READ, '0, 5'd7, 10'd0, '0);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_ADDI, 5'd9, 5'd0, 16'h8000),
            '0, '0, '0);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_ADDI, 5'd9, 5'd9, 16'h7FFF),
            '0, '0, '0);
    add_row(tie_pkg::KIND_SET_MEM, '0, 5'd0, 10'd1023, 32'hDEAD_BEEF);
    add_row(tie_pkg::KIND_SET_REG, '0, 5'd10, 10'd0, 32'd1000);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_LD, 5'd11, 5'd23, {5'd10, 11'd0}),
            '0, '0, '0);
    // store address far beyond the memory wraps back
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_ST, 5'd6, 5'd31, {5'd6, 11'd0}),
            '0, '0, '0);
    add_row(tie_pkg::KIND_READ, '0, 5'd11, 10'd31, '0);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_BNE, 5'd5, 5'd6, 16'hFFFD),
            '0, '0, '0);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_BEQ, 5'd5, 5'd5, 16'd5), '0, '0, '0);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_BEQ, 5'd5, 5'd6, 16'd9), '0, '0, '0);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_BNE, 5'd5, 5'd5, 16'd9), '0, '0, '0);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_JUMP, 5'd0, 5'd0, 16'h7FFF),
            '0, '0, '0);
    add_row(tie_pkg::KIND_EXEC, 32'hFFFF_FFFF, '0, '0, '0);
    add_row(tie_pkg::KIND_EXEC, 32'h0000_0000, '0, '0, '0);
    // write to the counter, then the increment lands on top
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_ADDI, 5'd0, 5'd3, 16'd5), '0, '0, '0);
    add_row(tie_pkg::KIND_SET_REG, '0, 5'd0, 10'd0, 32'hFFFF_FFFF);
    pin_last(32'hFFFF_FFFF, 1'b1, 32'd0, 32'd0);
    add_row(tie_pkg::KIND_EXEC, instr_word(tie_pkg::OPC_JUMP, 5'd0, 5'd0, 16'h8000),
            '0, '0, '0);
    add_length_row(16'hFFFF);
    add_row(tie_pkg::KIND_READ, '0, 5'd0, 10'd1023, '0);

    // Hold reset low at the start, then release it
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 8;
    recv_idle = 76;
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.set_len)
        set_length(r.len);
      else
        send_request(r.kind, pack_request(r.instr, r.ridx, r.maddr, r.value), r.pinned, r.want);
    end

    // Random requests over six program lengths and three idle mixes
    seg_len = '{16'hFFFF, 16'($urandom_range(2, 200)), 16'h0000, 16'h0001, 16'd300,
                16'($urandom)};
    for (int s = 0; s < 6; s++) begin
      case (s / 2)
        0: begin send_idle = 8;  recv_idle = 76; end
        1: begin send_idle = 76; recv_idle = 8;  end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      set_length(seg_len[s]);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        random_request(kind, data);
        send_request(kind, data, 1'b0, '0);
      end
    end

    // Drain and let the pipeline settle
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d requests, %0d statuses checked, %0d program lengths",
             n_sent, n_checked, n_lengths);
    $display("idle mixes: light sender/heavy receiver, reversed, none; mismatches: %0d",
             n_errors);
    if (n_errors == 0 && status_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
